@@ rtl/rle4_pkg.sv @@
// ----------------------------------------------------------------------------
// rle4_pkg
// Shared types and constants for the 4-bit run-length bitmap run decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package rle4_pkg;

  // Size limits, used as parameter defaults
  localparam int MAX_WIDTH_DEF  = 1024;
  localparam int MAX_HEIGHT_DEF = 1024;

  // Configuration port
  localparam int CFG_ADDR_W = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_ADDR_W-1:0] CFG_IDX_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_ADDR_W-1:0] CFG_IDX_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_ADDR_W-1:0] CFG_IDX_PALETTE_MASK = 2'd2;

  localparam logic [10:0] RST_IMAGE_WIDTH  = 11'd256;
  localparam logic [10:0] RST_IMAGE_HEIGHT = 11'd64;
  localparam logic [15:0] RST_PALETTE_MASK = 16'hFFFE;

  // Escape codes following a zero count byte
  localparam logic [7:0] ESC_EOL   = 8'd0;
  localparam logic [7:0] ESC_EOB   = 8'd1;
  localparam logic [7:0] ESC_DELTA = 8'd2;

  localparam logic [3:0] NIBBLE_MASK = 4'hF;

  typedef enum logic [2:0] {
    PH_COUNT,
    PH_COLOR,
    PH_ESCAPE,
    PH_DELTA_X,
    PH_DELTA_Y,
    PH_ABS,
    PH_PAD
  } phase_t;

  typedef struct packed {
    logic [10:0] image_width;
    logic [10:0] image_height;
    logic [15:0] palette_mask;
  } rle4_cfg_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
  } in_item_t;

  typedef struct packed {
    logic [9:0] row;
    logic [9:0] x_start;
    logic [7:0] pixel_count;
    logic       color_even;
    logic       color_odd;
    logic       image_done;
  } out_item_t;

endpackage

`default_nettype wire

@@ rtl/rle4_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// rle4_cfg_regs
// Configuration register file: width, height and palette mask.
// ----------------------------------------------------------------------------
`default_nettype none

module rle4_cfg_regs
  import rle4_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  output rle4_cfg_t                  cfg
);

  logic [10:0] image_width_r,  image_width_nxt;
  logic [10:0] image_height_r, image_height_nxt;
  logic [15:0] palette_mask_r, palette_mask_nxt;

  assign cfg_ready = 1'b1;

  always_comb begin
    image_width_nxt  = image_width_r;
    image_height_nxt = image_height_r;
    palette_mask_nxt = palette_mask_r;
    if (cfg_valid) begin
      case (cfg_addr)
        CFG_IDX_IMAGE_WIDTH:  image_width_nxt  = cfg_data[10:0];
        CFG_IDX_IMAGE_HEIGHT: image_height_nxt = cfg_data[10:0];
        CFG_IDX_PALETTE_MASK: palette_mask_nxt = cfg_data[15:0];
        default: ;  // unknown index: ignored
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r  <= RST_IMAGE_WIDTH;
      image_height_r <= RST_IMAGE_HEIGHT;
      palette_mask_r <= RST_PALETTE_MASK;
    end else begin
      image_width_r  <= image_width_nxt;
      image_height_r <= image_height_nxt;
      palette_mask_r <= palette_mask_nxt;
    end
  end

  assign cfg.image_width  = image_width_r;
  assign cfg.image_height = image_height_r;
  assign cfg.palette_mask = palette_mask_r;

endmodule

`default_nettype wire

@@ rtl/rle4_decode.sv @@
// ----------------------------------------------------------------------------
// rle4_decode
// Decoder state and per-byte logic: phase, position, run counters and
// the clipped run for one registered input item.
// ----------------------------------------------------------------------------
`default_nettype none

module rle4_decode
  import rle4_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  rle4_cfg_t      cfg,
  input  wire logic      step,
  input  in_item_t       item,
  output logic           res_valid,
  output out_item_t      res
);

  localparam int CW   = $clog2(MAX_WIDTH + 1);
  localparam int RW   = $clog2(MAX_HEIGHT);
  localparam int HW   = $clog2(MAX_HEIGHT + 1);
  localparam int WCMP = (CW > 11) ? CW : 11;
  localparam int HCMP = (HW > 11) ? HW : 11;
  localparam int KW   = (CW > 8) ? CW : 8;
  localparam int SW   = KW + 1;
  localparam int DW   = (RW > 8) ? RW : 8;
  localparam int RST_H = (int'(RST_IMAGE_HEIGHT) > MAX_HEIGHT) ?
                         MAX_HEIGHT : int'(RST_IMAGE_HEIGHT);
  localparam logic [RW-1:0] RST_ROW = RW'(RST_H - 1);

  phase_t        phase_r, phase_nxt;
  logic [CW-1:0] column_r, column_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic [7:0]    run_r, run_nxt;
  logic [7:0]    abs_r, abs_nxt;
  logic          pad_r, pad_nxt;
  logic          fin_r, fin_nxt;

  logic [CW-1:0] eff_w;
  logic [HW-1:0] eff_h;
  logic [RW-1:0] h_m1;

  phase_t        cur_phase;
  logic [CW-1:0] cur_col;
  logic [RW-1:0] cur_row;
  logic [7:0]    cur_run, cur_abs;
  logic          cur_pad, cur_fin;

  logic [7:0]    b;
  logic [8:0]    b_p1;
  logic          row_oor;
  logic [7:0]    abs_n, abs_after;
  logic [7:0]    run_n;
  logic [7:0]    adv_amt;
  logic [SW-1:0] col_sum;
  logic [CW-1:0] col_sat;
  logic [CW-1:0] room;
  logic [KW-1:0] k_ext;
  logic          run_fits;
  logic          dy_under;
  logic [DW-1:0] row_sub;
  logic          valid_c;
  out_item_t     res_c;

  // Effective size: register values clamped to the build limits
  always_comb begin
    if (WCMP'(cfg.image_width) > WCMP'(MAX_WIDTH)) eff_w = CW'(MAX_WIDTH);
    else                                           eff_w = CW'(cfg.image_width);
    if (HCMP'(cfg.image_height) > HCMP'(MAX_HEIGHT)) eff_h = HW'(MAX_HEIGHT);
    else                                             eff_h = HW'(cfg.image_height);
  end

  assign h_m1 = (eff_h != '0) ? RW'(eff_h - HW'(1)) : '0;

  // first_byte restarts the image before the byte is decoded
  assign cur_phase = item.first_byte ? PH_COUNT : phase_r;
  assign cur_col   = item.first_byte ? '0       : column_r;
  assign cur_row   = item.first_byte ? h_m1     : row_r;
  assign cur_run   = item.first_byte ? '0       : run_r;
  assign cur_abs   = item.first_byte ? '0       : abs_r;
  assign cur_pad   = item.first_byte ? 1'b0     : pad_r;
  assign cur_fin   = item.first_byte ? 1'b0     : fin_r;

  assign b       = item.data_byte;
  assign b_p1    = 9'(b) + 9'd1;
  assign row_oor = HW'(cur_row) >= eff_h;

  assign abs_n     = (cur_abs < 8'd2) ? cur_abs : 8'd2;
  assign abs_after = cur_abs - abs_n;

  assign run_n   = (cur_phase == PH_ABS) ? abs_n : cur_run;
  assign adv_amt = (cur_phase == PH_DELTA_X) ? b : run_n;

  // Column advance, saturating at the width limit
  assign col_sum = SW'(cur_col) + SW'(adv_amt);
  assign col_sat = (col_sum > SW'(MAX_WIDTH)) ? CW'(MAX_WIDTH) : CW'(col_sum);

  // Clip against the right edge
  assign run_fits = cur_col < eff_w;
  assign room     = eff_w - cur_col;
  assign k_ext    = (KW'(run_n) < KW'(room)) ? KW'(run_n) : KW'(room);

  assign dy_under = DW'(b) > DW'(cur_row);
  assign row_sub  = DW'(cur_row) - DW'(b);

  // Next phase
  always_comb begin
    phase_nxt = cur_phase;
    if (!cur_fin) begin
      case (cur_phase)
        PH_COUNT:   phase_nxt = (b == ESC_EOL) ? PH_ESCAPE : PH_COLOR;
        PH_COLOR:   phase_nxt = PH_COUNT;
        PH_ESCAPE: begin
          if (b == ESC_DELTA)                         phase_nxt = PH_DELTA_X;
          else if (b > ESC_DELTA && !row_oor)         phase_nxt = PH_ABS;
          else                                        phase_nxt = PH_COUNT;
        end
        PH_DELTA_X: phase_nxt = PH_DELTA_Y;
        PH_DELTA_Y: phase_nxt = PH_COUNT;
        PH_ABS: begin
          if (row_oor)                phase_nxt = PH_COUNT;
          else if (abs_after == '0)   phase_nxt = cur_pad ? PH_PAD : PH_COUNT;
          else                        phase_nxt = PH_ABS;
        end
        PH_PAD:     phase_nxt = PH_COUNT;
        default:    phase_nxt = PH_COUNT;
      endcase
    end
  end

  // Datapath and result
  always_comb begin
    column_nxt = cur_col;
    row_nxt    = cur_row;
    run_nxt    = cur_run;
    abs_nxt    = cur_abs;
    pad_nxt    = cur_pad;
    fin_nxt    = cur_fin;
    valid_c    = 1'b0;
    res_c      = '0;

    if (!cur_fin) begin
      case (cur_phase)
        PH_COUNT: begin
          if (b != ESC_EOL) run_nxt = b;
        end
        PH_COLOR: begin
          if (row_oor) begin
            fin_nxt = 1'b1;
            valid_c = 1'b1;
            res_c.image_done = 1'b1;
          end else begin
            column_nxt = col_sat;
            valid_c    = run_fits && (k_ext != '0);
          end
        end
        PH_ESCAPE: begin
          if (b == ESC_EOL) begin
            column_nxt = '0;
            if (cur_row == '0) begin
              fin_nxt = 1'b1;
              valid_c = 1'b1;
              res_c.image_done = 1'b1;
            end else begin
              row_nxt = cur_row - RW'(1);
            end
          end else if (b == ESC_EOB) begin
            fin_nxt = 1'b1;
            valid_c = 1'b1;
            res_c.image_done = 1'b1;
          end else if (b != ESC_DELTA) begin
            if (row_oor) begin
              fin_nxt = 1'b1;
              valid_c = 1'b1;
              res_c.image_done = 1'b1;
            end else begin
              abs_nxt = b;
              // pad byte when the data byte count is odd
              pad_nxt = b_p1[1];
            end
          end
        end
        PH_DELTA_X: column_nxt = col_sat;
        PH_DELTA_Y: begin
          if (dy_under) begin
            fin_nxt = 1'b1;
            valid_c = 1'b1;
            res_c.image_done = 1'b1;
          end else begin
            row_nxt = RW'(row_sub);
          end
        end
        PH_ABS: begin
          if (row_oor) begin
            fin_nxt = 1'b1;
            valid_c = 1'b1;
            res_c.image_done = 1'b1;
          end else begin
            abs_nxt = abs_after;
            if (abs_n != '0) begin
              column_nxt = col_sat;
              valid_c    = run_fits && (k_ext != '0);
            end
          end
        end
        PH_PAD: ;
        default: ;
      endcase
    end

    if (valid_c && !res_c.image_done) begin
      res_c.row         = 10'(cur_row);
      res_c.x_start     = 10'(cur_col);
      res_c.pixel_count = k_ext[7:0];
      res_c.color_even  = cfg.palette_mask[b[7:4]];
      res_c.color_odd   = cfg.palette_mask[b[3:0] & NIBBLE_MASK];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_COUNT;
      column_r <= '0;
      row_r    <= RST_ROW;
      run_r    <= '0;
      abs_r    <= '0;
      pad_r    <= 1'b0;
      fin_r    <= 1'b0;
    end else if (step) begin
      phase_r  <= phase_nxt;
      column_r <= column_nxt;
      row_r    <= row_nxt;
      run_r    <= run_nxt;
      abs_r    <= abs_nxt;
      pad_r    <= pad_nxt;
      fin_r    <= fin_nxt;
    end
  end

  assign res_valid = step && valid_c;
  assign res       = res_c;

`ifndef NO_ASSERTIONS
  a_done_is_empty: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && res.image_done |-> res.pixel_count == '0 && res.row == '0)
    else $error("done marker carries a run");

  a_run_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && !res.image_done |-> res.pixel_count != '0)
    else $error("empty run emitted");

  a_quiet_when_finished: assert property (@(posedge clk) disable iff (!rst_n)
    step && fin_r && !item.first_byte |-> !res_valid)
    else $error("result after image finished");

  a_done_sets_finished: assert property (@(posedge clk) disable iff (!rst_n)
    res_valid && res.image_done |=> fin_r && phase_r == PH_COUNT)
    else $error("done marker did not finish the image");

  a_column_bound: assert property (@(posedge clk) disable iff (!rst_n)
    column_r <= CW'(MAX_WIDTH))
    else $error("column beyond width limit");
`endif

endmodule

`default_nettype wire

@@ rtl/rle4_out_reg.sv @@
// ----------------------------------------------------------------------------
// rle4_out_reg
// Result register: holds one run item until the output side takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module rle4_out_reg
  import rle4_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic load,
  input  wire logic load_valid,
  input  out_item_t load_item,
  output logic      out_valid,
  input  wire logic out_ready,
  output out_item_t out_data
);

  logic      valid_r, valid_nxt;
  out_item_t item_r;

  // load only happens when the register is empty or being drained
  assign valid_nxt = load ? load_valid : (valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= 1'b0;
    else        valid_r <= valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (load && load_valid) item_r <= load_item;
  end

  assign out_valid = valid_r;
  assign out_data  = item_r;

endmodule

`default_nettype wire

@@ rtl/rle4_bitmap_run_decoder.sv @@
// ----------------------------------------------------------------------------
// rle4_bitmap_run_decoder
// 4-bit run-length bitmap decoder: compressed bytes in, clipped one-bit
// pixel runs out, bottom row first.
// ----------------------------------------------------------------------------
//
//   channel   dir  handshake            payload
//   in_       in   in_valid/in_ready    in_item_t  {data_byte, first_byte}
//   out_      out  out_valid/out_ready  out_item_t {row, x_start, pixel_count,
//                                                  color_even, color_odd,
//                                                  image_done}
//   cfg_      in   cfg_valid/cfg_ready  cfg_addr (register index), cfg_data
//
// One byte per cycle while out_ready keeps up: input register, phase logic,
// result register; out_valid rises once an item has passed both registers.
// A byte gives zero or one run item; a full result register with out_ready
// low holds the input register, and in_ready drops once both are full.
// Synchronous active-low reset; no clearing pass, ready right after reset.
// cfg_ready is always high; registers take effect on the next decoded byte.
// ----------------------------------------------------------------------------
`default_nettype none

module rle4_bitmap_run_decoder
  import rle4_pkg::*;
#(
  parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,

  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  in_item_t                   in_data,

  output logic                       out_valid,
  input  wire logic                  out_ready,
  output out_item_t                  out_data,

  input  wire logic                  cfg_valid,
  output logic                       cfg_ready,
  input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  rle4_cfg_t cfg;
  logic      s1_valid_r, s1_valid_nxt;
  in_item_t  s1_item_r;
  logic      step;
  logic      res_valid;
  out_item_t res;

  rle4_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Input register
  assign step         = s1_valid_r && (!out_valid || out_ready);
  assign in_ready     = !s1_valid_r || step;
  assign s1_valid_nxt = (in_valid && in_ready) ? 1'b1 : (step ? 1'b0 : s1_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) s1_valid_r <= 1'b0;
    else        s1_valid_r <= s1_valid_nxt;
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) s1_item_r <= in_data;
  end

  rle4_decode #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg),
    .step      (step),
    .item      (s1_item_r),
    .res_valid (res_valid),
    .res       (res)
  );

  rle4_out_reg u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .load       (step),
    .load_valid (res_valid),
    .load_item  (res),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .out_data   (out_data)
  );

`ifndef NO_ASSERTIONS
  a_stall_holds_stage: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !step |=> s1_valid_r && $stable(s1_item_r))
    else $error("input stage lost a stalled item");

  a_no_step_when_blocked: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !step)
    else $error("decode advanced into a full result register");

  a_result_follows_step: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(step))
    else $error("result appeared without a decoded item");
`endif

endmodule

`default_nettype wire

@@ tb/sv/rle4_bitmap_run_decoder_tb.sv @@
// ----------------------------------------------------------------------------
// rle4_bitmap_run_decoder_tb
// Self-checking bench for the 4-bit run-length bitmap run decoder. A
// behavioral decoder tracks phase, position and registers for each accepted
// byte and queues the run items it produces. Every result is compared field
// by field against that queue. Directed streams cover the escapes, clipping
// and register corner cases. Random well-formed images with noise follow,
// with random gaps on the input and random stalls on the output.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module rle4_bitmap_run_decoder_tb;
  import rle4_pkg::*;

  localparam int            RANDOM_BYTES  = 400;
  localparam int            SETTLE_CYCLES = 6;
  localparam int            TIMEOUT_NS    = 2_000_000;
  localparam logic [7:0]    ESC_INTRO     = 8'd0;  // zero count introduces an escape
  localparam logic [CFG_ADDR_W-1:0] CFG_IDX_UNUSED = 2'd3;

  logic       clk       = 1'b0;
  logic       rst_n     = 1'b0;
  logic       in_valid  = 1'b0;
  logic       in_ready;
  in_item_t   in_data   = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  out_item_t  out_data;
  logic       cfg_valid = 1'b0;
  logic       cfg_ready;
  logic [CFG_ADDR_W-1:0] cfg_addr = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // decoder state as seen by the bench
  logic [10:0] cfg_width;
  logic [10:0] cfg_height;
  logic [15:0] cfg_palette;
  phase_t      dec_phase;
  logic [10:0] dec_column;
  logic [10:0] dec_row;
  logic [7:0]  dec_run_len;
  logic [7:0]  dec_abs_left;
  logic        dec_pad;
  logic        dec_finished;

  out_item_t pending_runs[$];
  int        errors        = 0;
  int        bytes_decoded = 0;
  bit        new_image     = 1'b0;
  bit        gaps_on       = 1'b1;
  bit        stalls_on     = 1'b1;

  rle4_bitmap_run_decoder i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_addr  (cfg_addr),
    .cfg_data  (cfg_data)
  );

  always #2 clk = ~clk;

  // ---------------------------------------------------------------- decoder
  function automatic int clipped_width();
    return (cfg_width > MAX_WIDTH_DEF) ? MAX_WIDTH_DEF : int'(cfg_width);
  endfunction

  function automatic int clipped_height();
    return (cfg_height > MAX_HEIGHT_DEF) ? MAX_HEIGHT_DEF : int'(cfg_height);
  endfunction

  function automatic void restart_image();
    int h;
    h = clipped_height();
    dec_phase    = PH_COUNT;
    dec_column   = '0;
    dec_row      = (h != 0) ? 11'(h - 1) : '0;
    dec_run_len  = '0;
    dec_abs_left = '0;
    dec_pad      = 1'b0;
    dec_finished = 1'b0;
  endfunction

  function automatic void advance_columns(input int n);
    int c;
    c = int'(dec_column) + n;
    dec_column = (c > MAX_WIDTH_DEF) ? 11'(MAX_WIDTH_DEF) : 11'(c);
  endfunction

  function automatic bit mark_done(output out_item_t r);
    dec_finished = 1'b1;
    dec_phase    = PH_COUNT;
    r            = '0;
    r.image_done = 1'b1;
    return 1'b1;
  endfunction

  function automatic bit emit_pixels(input int n, input logic [7:0] colors,
                                     output out_item_t r);
    int w;
    int room;
    int k;
    w = clipped_width();
    r = '0;
    emit_pixels = 1'b0;
    if (int'(dec_column) < w) begin
      room = w - int'(dec_column);
      k = (n < room) ? n : room;
      if (k > 0) begin
        r.row         = dec_row[9:0];
        r.x_start     = dec_column[9:0];
        r.pixel_count = 8'(k);
        r.color_even  = cfg_palette[colors[7:4]];
        r.color_odd   = cfg_palette[colors[3:0] & NIBBLE_MASK];
        emit_pixels   = 1'b1;
      end
    end
    advance_columns(n);
  endfunction

  // one compressed byte in, zero or one run item out
  function automatic bit decode_byte(input in_item_t it, output out_item_t r);
    logic [7:0] b;
    int n;
    b = it.data_byte;
    r = '0;
    decode_byte = 1'b0;
    if (it.first_byte) restart_image();
    if (dec_finished) return 1'b0;
    case (dec_phase)
      PH_COUNT: begin
        if (b == ESC_INTRO) begin
          dec_phase = PH_ESCAPE;
        end else begin
          dec_run_len = b;
          dec_phase   = PH_COLOR;
        end
      end
      PH_COLOR: begin
        dec_phase = PH_COUNT;
        if (int'(dec_row) >= clipped_height()) return mark_done(r);
        return emit_pixels(int'(dec_run_len), b, r);
      end
      PH_ESCAPE: begin
        dec_phase = PH_COUNT;
        case (b)
          ESC_EOL: begin
            dec_column = '0;
            if (dec_row == '0) return mark_done(r);
            dec_row = dec_row - 11'd1;
          end
          ESC_EOB:   return mark_done(r);
          ESC_DELTA: dec_phase = PH_DELTA_X;
          default: begin
            if (int'(dec_row) >= clipped_height()) return mark_done(r);
            dec_abs_left = b;
            dec_pad      = 1'(((int'(b) + 1) >> 1) % 2);  // odd data byte count
            dec_phase    = PH_ABS;
          end
        endcase
      end
      PH_DELTA_X: begin
        advance_columns(int'(b));
        dec_phase = PH_DELTA_Y;
      end
      PH_DELTA_Y: begin
        dec_phase = PH_COUNT;
        if (int'(b) > int'(dec_row)) return mark_done(r);
        dec_row = dec_row - 11'(b);
      end
      PH_ABS: begin
        if (int'(dec_row) >= clipped_height()) return mark_done(r);
        n = (dec_abs_left < 8'd2) ? int'(dec_abs_left) : 2;
        dec_abs_left = dec_abs_left - 8'(n);
        if (dec_abs_left == '0) dec_phase = dec_pad ? PH_PAD : PH_COUNT;
        if (n == 0) return 1'b0;
        return emit_pixels(n, b, r);
      end
      default: dec_phase = PH_COUNT;  // pad byte is dropped
    endcase
  endfunction

  // ---------------------------------------------------------------- idling
  function automatic int pick_gap();
    int r;
    if (!gaps_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  initial begin
    forever begin
      @(posedge clk);
      if (stalls_on && $urandom_range(0, 3) == 0) begin
        out_ready <= 1'b0;
        repeat (($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(8, 40))
          @(posedge clk);
      end
      out_ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------- drivers
  task automatic send_byte(input logic [7:0] b);
    in_item_t  it;
    out_item_t run;
    int        gap;
    it.data_byte  = b;
    it.first_byte = new_image;
    new_image     = 1'b0;
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_decoded++;
    if (decode_byte(it, run)) pending_runs.push_back(run);
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_addr  <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_IDX_IMAGE_WIDTH:  cfg_width   = val[10:0];
      CFG_IDX_IMAGE_HEIGHT: cfg_height  = val[10:0];
      CFG_IDX_PALETTE_MASK: cfg_palette = val;
      default: ;
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  // wait until every queued run has come out and the pipeline is empty
  task automatic drain_runs();
    in_valid <= 1'b0;
    while (pending_runs.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // ---------------------------------------------------------------- checker
  always @(posedge clk) begin : check_runs
    out_item_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_runs.size() == 0) begin
        $error("unexpected run item: row %0d x_start %0d pixel_count %0d image_done %0b",
               out_data.row, out_data.x_start, out_data.pixel_count, out_data.image_done);
        errors++;
      end else begin
        want = pending_runs.pop_front();
        if (out_data.row != want.row) begin
          $error("row: expected %0d, got %0d", want.row, out_data.row);
          errors++;
        end
        if (out_data.x_start != want.x_start) begin
          $error("x_start: expected %0d, got %0d", want.x_start, out_data.x_start);
          errors++;
        end
        if (out_data.pixel_count != want.pixel_count) begin
          $error("pixel_count: expected %0d, got %0d", want.pixel_count,
                 out_data.pixel_count);
          errors++;
        end
        if (out_data.color_even != want.color_even) begin
          $error("color_even: expected %0b, got %0b", want.color_even, out_data.color_even);
          errors++;
        end
        if (out_data.color_odd != want.color_odd) begin
          $error("color_odd: expected %0b, got %0b", want.color_odd, out_data.color_odd);
          errors++;
        end
        if (out_data.image_done != want.image_done) begin
          $error("image_done: expected %0b, got %0b", want.image_done, out_data.image_done);
          errors++;
        end
      end
    end
  end

  // ---------------------------------------------------------------- tests
  // reset registers: width 256, height 64
  task automatic test_runs_and_escapes();
    new_image = 1'b1;
    send_byte(ESC_INTRO);      // absolute run of 5: last data byte gives one pixel
    send_byte(8'd5);
    send_byte(8'h12);
    send_byte(8'h34);
    send_byte(8'h5F);
    send_byte(8'hFF);          // pad, ignored
    send_byte(8'd255);         // full count, clipped at the right edge
    send_byte(8'hF0);
    send_byte(ESC_INTRO);      // delta far past the edge, one row up
    send_byte(ESC_DELTA);
    send_byte(8'd255);
    send_byte(8'd1);
    send_byte(8'd1);           // fully clipped, no item
    send_byte(8'h0F);
    send_byte(ESC_INTRO);
    send_byte(ESC_EOL);
    send_byte(8'd4);
    send_byte(8'h01);
    send_byte(ESC_INTRO);
    send_byte(ESC_EOB);
    send_byte(8'hAA);          // after the done marker: ignored
  endtask

  task automatic test_row_underflow();
    drain_runs();
    write_reg(CFG_IDX_IMAGE_WIDTH, 16'hFFFF);   // oversized, taken as the maximum
    write_reg(CFG_IDX_IMAGE_HEIGHT, 16'd1);
    new_image = 1'b1;
    send_byte(ESC_INTRO);
    send_byte(ESC_EOL);        // end of line on row 0
    new_image = 1'b1;
    send_byte(8'd200);
    send_byte(8'h77);
    send_byte(ESC_INTRO);
    send_byte(ESC_DELTA);
    send_byte(8'd0);
    send_byte(8'd1);           // delta below row 0
  endtask

  task automatic test_sizes_and_registers();
    drain_runs();
    write_reg(CFG_IDX_IMAGE_WIDTH, 16'd0);
    write_reg(CFG_IDX_IMAGE_HEIGHT, 16'd8);
    new_image = 1'b1;
    send_byte(8'd3);           // zero width: all clipped
    send_byte(8'h11);
    drain_runs();
    write_reg(CFG_IDX_IMAGE_HEIGHT, 16'd0);
    new_image = 1'b1;
    send_byte(8'd3);           // zero height: done marker
    send_byte(8'h11);
    drain_runs();
    write_reg(CFG_IDX_IMAGE_WIDTH, 16'd16);
    write_reg(CFG_IDX_IMAGE_HEIGHT, 16'd64);
    new_image = 1'b1;
    send_byte(8'd20);
    send_byte(8'h9A);
    drain_runs();
    write_reg(CFG_IDX_IMAGE_HEIGHT, 16'd8);     // current row now outside the bitmap
    send_byte(8'd1);
    send_byte(8'h9A);
    drain_runs();
    write_reg(CFG_IDX_UNUSED, 16'h0000);
    write_reg(CFG_IDX_PALETTE_MASK, 16'h8001);
    new_image = 1'b1;
    send_byte(8'd2);
    send_byte(8'hF0);
  endtask

  task automatic send_random_image(input bit restart);
    int ops;
    int kind;
    int n;
    int nbytes;
    new_image = restart;
    ops = $urandom_range(2, 14);
    for (int i = 0; i < ops; i++) begin
      kind = $urandom_range(0, 99);
      if (kind < 45) begin
        n = $urandom_range(0, 99);
        if (n < 70)      n = $urandom_range(1, 20);
        else if (n < 85) n = $urandom_range(1, 255);
        else             n = $urandom_range(200, 255);
        send_byte(8'(n));
        send_byte(8'($urandom_range(0, 255)));
      end else if (kind < 65) begin
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(3, 255) : $urandom_range(3, 12);
        nbytes = (n + 1) / 2;
        send_byte(ESC_INTRO);
        send_byte(8'(n));
        repeat (nbytes) send_byte(8'($urandom_range(0, 255)));
        if (nbytes % 2 != 0) send_byte(8'($urandom_range(0, 255)));
      end else if (kind < 82) begin
        send_byte(ESC_INTRO);
        send_byte(ESC_EOL);
      end else if (kind < 92) begin
        send_byte(ESC_INTRO);
        send_byte(ESC_DELTA);
        send_byte(($urandom_range(0, 5) == 0) ? 8'd255 : 8'($urandom_range(0, 20)));
        send_byte(($urandom_range(0, 7) == 0) ? 8'($urandom_range(0, 255))
                                              : 8'($urandom_range(0, 2)));
      end else begin
        // stray bytes that break the sequence, now and then a restart
        repeat ($urandom_range(1, 4)) begin
          new_image = ($urandom_range(0, 7) == 0);
          send_byte(8'($urandom_range(0, 255)));
        end
      end
    end
    if ($urandom_range(0, 4) != 0) begin
      send_byte(ESC_INTRO);
      send_byte(ESC_EOB);
    end
    if ($urandom_range(0, 3) == 0) repeat (2) send_byte(8'($urandom_range(0, 255)));
  endtask

  task automatic test_random_images();
    int base;
    int sel;
    int w;
    int h;
    logic [15:0] pal;
    base = bytes_decoded;
    while (bytes_decoded - base < RANDOM_BYTES) begin
      drain_runs();
      sel = $urandom_range(0, 9);
      case (sel)
        0:       w = 1;
        1:       w = MAX_WIDTH_DEF;
        2:       w = $urandom_range(MAX_WIDTH_DEF + 1, 2047);
        3:       w = 0;
        4:       w = $urandom_range(1, MAX_WIDTH_DEF);
        default: w = $urandom_range(1, 64);
      endcase
      sel = $urandom_range(0, 11);
      case (sel)
        0:       h = 1;
        1:       h = MAX_HEIGHT_DEF;
        2:       h = $urandom_range(MAX_HEIGHT_DEF + 1, 2047);
        3:       h = 0;
        4:       h = $urandom_range(1, MAX_HEIGHT_DEF);
        default: h = $urandom_range(1, 12);
      endcase
      sel = $urandom_range(0, 9);
      pal = (sel == 0) ? 16'h0000 : (sel == 1) ? 16'hFFFF : 16'($urandom_range(0, 65535));
      // upper data bits beyond the 11-bit size registers are random
      write_reg(CFG_IDX_IMAGE_WIDTH, {5'($urandom_range(0, 31)), 11'(w)});
      write_reg(CFG_IDX_IMAGE_HEIGHT, {5'($urandom_range(0, 31)), 11'(h)});
      write_reg(CFG_IDX_PALETTE_MASK, pal);
      if ($urandom_range(0, 3) == 0)
        write_reg(CFG_IDX_UNUSED, 16'($urandom_range(0, 65535)));
      gaps_on   = ($urandom_range(0, 3) != 0);
      stalls_on = ($urandom_range(0, 3) != 0);
      // sometimes carry the previous image across the register change
      send_random_image($urandom_range(0, 4) != 0);
      repeat ($urandom_range(1, 4)) send_random_image(1'b1);
    end
  endtask

  initial begin
    cfg_width   = RST_IMAGE_WIDTH;
    cfg_height  = RST_IMAGE_HEIGHT;
    cfg_palette = RST_PALETTE_MASK;
    restart_image();
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_runs_and_escapes();
    test_row_underflow();
    test_sizes_and_registers();
    test_random_images();
    drain_runs();
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("DONE: errors detected");
    $finish;
  end

endmodule
